@@ src/rm2q_pkg.sv @@
// Shared constants and types for the rotation matrix to quaternion block.
package rm2q_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int ELEM_W        = 16;
	localparam int NUM_W         = 18;
	localparam int MAG_W         = 17;

	typedef enum logic [1:0] {
		SEL_TRACE,
		SEL_X,
		SEL_Y,
		SEL_Z
	} sel_t;

endpackage

@@ src/rm2q_sqrt_cell.sv @@
// One digit cell of the pipelined square root chain.
module rm2q_sqrt_cell #(
	parameter int RAD_W  = 34,
	parameter int ROOT_W = 17,
	parameter int PAY_W  = 56
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [RAD_W-1:0]    in_rad,
	input  logic [ROOT_W+1:0]   in_rem,
	input  logic [ROOT_W-1:0]   in_root,
	input  logic [PAY_W-1:0]    in_pay,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [RAD_W-1:0]    out_rad,
	output logic [ROOT_W+1:0]   out_rem,
	output logic [ROOT_W-1:0]   out_root,
	output logic [PAY_W-1:0]    out_pay
);

	localparam int REM_W = ROOT_W + 2;

	logic [REM_W+1:0]  cat;
	logic [REM_W+1:0]  trial;
	logic              ge;
	logic [REM_W+1:0]  diff;
	logic              v_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [PAY_W-1:0]  pay_q;

	// Bring down the next two radicand bits and try to append a one to the root.
	assign cat   = {in_rem, in_rad[RAD_W-1 -: 2]};
	assign trial = {2'b00, in_root, 2'b01};
	assign ge    = (cat >= trial);
	assign diff  = ge ? (cat - trial) : cat;

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rad_q  <= in_rad << 2;
			rem_q  <= diff[REM_W-1:0];
			root_q <= {in_root[ROOT_W-2:0], ge};
			pay_q  <= in_pay;
		end
	end

	assign out_valid = v_q;
	assign out_rad   = rad_q;
	assign out_rem   = rem_q;
	assign out_root  = root_q;
	assign out_pay   = pay_q;

endmodule

@@ src/rm2q_div_cell.sv @@
// One quotient bit cell of the three lane pipelined divider chain.
module rm2q_div_cell #(
	parameter int DIV_W = 32,
	parameter int DEN_W = 18,
	parameter int PAY_W = 22
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [2:0][DIV_W-1:0]      in_num,
	input  logic [2:0][DEN_W-1:0]      in_rem,
	input  logic [DEN_W-1:0]           in_den,
	input  logic [PAY_W-1:0]           in_pay,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [2:0][DIV_W-1:0]      out_num,
	output logic [2:0][DEN_W-1:0]      out_rem,
	output logic [DEN_W-1:0]           out_den,
	output logic [PAY_W-1:0]           out_pay
);

	logic [2:0][DEN_W:0]   cat;
	logic [2:0]            ge;
	logic [2:0][DEN_W:0]   diff;
	logic [2:0][DIV_W-1:0] num_n;
	logic                  v_q;
	logic [2:0][DIV_W-1:0] num_q;
	logic [2:0][DEN_W-1:0] rem_q;
	logic [DEN_W-1:0]      den_q;
	logic [PAY_W-1:0]      pay_q;

	// The dividend shifts out at the top while quotient bits shift in at the bottom.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cat[i]   = {in_rem[i], in_num[i][DIV_W-1]};
			ge[i]    = (cat[i] >= {1'b0, in_den});
			diff[i]  = ge[i] ? (cat[i] - {1'b0, in_den}) : cat[i];
			num_n[i] = {in_num[i][DIV_W-2:0], ge[i]};
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			for (int i = 0; i < 3; i++) begin
				num_q[i] <= num_n[i];
				rem_q[i] <= diff[i][DEN_W-1:0];
			end
			den_q <= in_den;
			pay_q <= in_pay;
		end
	end

	assign out_valid = v_q;
	assign out_num   = num_q;
	assign out_rem   = rem_q;
	assign out_den   = den_q;
	assign out_pay   = pay_q;

endmodule

@@ src/rotation_matrix_to_quaternion.sv @@
// Rotation matrix to quaternion converter, trace method, built as chains of cells.
// An input passes through the root chain cells, the divider chain cells and the output register.
// Throughput: one matrix per cycle unless the output stalls; every cell of the root chain and of the divider
// chain holds its own item, and a stalled output lets earlier stages close up bubbles.
// Reset clears only the valid bits of the cells and the output register.
// The root chain produces one root bit per cell, the divider one quotient bit per cell.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = rm2q_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [rm2q_pkg::ELEM_W-1:0] row0_col0,
	input  logic signed [rm2q_pkg::ELEM_W-1:0] row0_col1,
	input  logic signed [rm2q_pkg::ELEM_W-1:0] row0_col2,
	input  logic signed [rm2q_pkg::ELEM_W-1:0] row1_col0,
	input  logic signed [rm2q_pkg::ELEM_W-1:0] row1_col1,
	input  logic signed [rm2q_pkg::ELEM_W-1:0] row1_col2,
	input  logic signed [rm2q_pkg::ELEM_W-1:0] row2_col0,
	input  logic signed [rm2q_pkg::ELEM_W-1:0] row2_col1,
	input  logic signed [rm2q_pkg::ELEM_W-1:0] row2_col2,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [rm2q_pkg::ELEM_W-1:0] quat_w,
	output logic signed [rm2q_pkg::ELEM_W-1:0] quat_x,
	output logic signed [rm2q_pkg::ELEM_W-1:0] quat_y,
	output logic signed [rm2q_pkg::ELEM_W-1:0] quat_z,
	output logic                         identity_fallback
);

	import rm2q_pkg::*;

	// The root argument holds a sum of three elements plus one in the chosen format.
	localparam int ARG_W  = ((FRAC_BITS + 2 > NUM_W) ? FRAC_BITS + 2 : NUM_W) + 1;
	localparam int RAD_W0 = ARG_W + FRAC_BITS;
	localparam int RAD_W  = RAD_W0 + (RAD_W0 % 2);
	localparam int ROOT_W = RAD_W / 2;
	localparam int DEN_W  = ROOT_W + 1;
	localparam int DIV_W  = MAG_W + FRAC_BITS + 1;
	localparam int SP_W   = 3 * NUM_W + 2;
	localparam int DP_W   = 2 + 3 + ROOT_W;
	localparam logic [ELEM_W-1:0] ID_W =
		ELEM_W'((FRAC_BITS >= ELEM_W - 1) ? 32767 : (1 << FRAC_BITS));
	localparam logic [ELEM_W-1:0] POS_MAX = 16'h7fff;
	localparam logic [ELEM_W-1:0] NEG_MAX = 16'h8000;

	// Front end: pick the branch, form the root argument and the three numerators.
	logic signed [NUM_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [NUM_W-1:0] trace_c, combo_c;
	logic signed [ARG_W-1:0] arg_c;
	logic [RAD_W-1:0]        rad_c;
	sel_t                    sel_c;
	logic signed [NUM_W-1:0] n0_c, n1_c, n2_c;

	assign m00 = NUM_W'(row0_col0);
	assign m01 = NUM_W'(row0_col1);
	assign m02 = NUM_W'(row0_col2);
	assign m10 = NUM_W'(row1_col0);
	assign m11 = NUM_W'(row1_col1);
	assign m12 = NUM_W'(row1_col2);
	assign m20 = NUM_W'(row2_col0);
	assign m21 = NUM_W'(row2_col1);
	assign m22 = NUM_W'(row2_col2);

	assign trace_c = m00 + m11 + m22;

	always_comb begin
		if (trace_c > 0) begin
			sel_c   = SEL_TRACE;
			combo_c = trace_c;
			n0_c    = m21 - m12;
			n1_c    = m02 - m20;
			n2_c    = m10 - m01;
		end else if (m00 >= m11 && m00 >= m22) begin
			sel_c   = SEL_X;
			combo_c = m00 - m11 - m22;
			n0_c    = m21 - m12;
			n1_c    = m10 + m01;
			n2_c    = m20 + m02;
		end else if (m11 >= m00 && m11 >= m22) begin
			sel_c   = SEL_Y;
			combo_c = m11 - m22 - m00;
			n0_c    = m02 - m20;
			n1_c    = m01 + m10;
			n2_c    = m21 + m12;
		end else begin
			sel_c   = SEL_Z;
			combo_c = m22 - m00 - m11;
			n0_c    = m10 - m01;
			n1_c    = m02 + m20;
			n2_c    = m12 + m21;
		end
	end

	assign arg_c = ARG_W'(combo_c) + (ARG_W'(1) << FRAC_BITS);
	assign rad_c = (arg_c > 0) ?
		({{(RAD_W - ARG_W){1'b0}}, arg_c} << FRAC_BITS) : '0;

	// Square root chain: one cell per root bit.
	logic [ROOT_W:0]                 sq_valid;
	logic [ROOT_W:0]                 sq_ready;
	logic [ROOT_W:0][RAD_W-1:0]      sq_rad;
	logic [ROOT_W:0][ROOT_W+1:0]     sq_rem;
	logic [ROOT_W:0][ROOT_W-1:0]     sq_root;
	logic [ROOT_W:0][SP_W-1:0]       sq_pay;

	assign sq_valid[0] = in_valid;
	assign in_ready    = sq_ready[0];
	assign sq_rad[0]   = rad_c;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	// Lane i of the packed numerator field carries numerator i.
	assign sq_pay[0]   = {sel_c, n2_c, n1_c, n0_c};

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		rm2q_sqrt_cell #(
			.RAD_W  (RAD_W),
			.ROOT_W (ROOT_W),
			.PAY_W  (SP_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_valid[k]),
			.in_ready  (sq_ready[k]),
			.in_rad    (sq_rad[k]),
			.in_rem    (sq_rem[k]),
			.in_root   (sq_root[k]),
			.in_pay    (sq_pay[k]),
			.out_valid (sq_valid[k+1]),
			.out_ready (sq_ready[k+1]),
			.out_rad   (sq_rad[k+1]),
			.out_rem   (sq_rem[k+1]),
			.out_root  (sq_root[k+1]),
			.out_pay   (sq_pay[k+1])
		);
	end

	// Between the chains: the divisor is twice the root, and half the divisor is added
	// to each scaled magnitude so that truncating division rounds half away from zero.
	logic [ROOT_W-1:0]           s_mid;
	logic [1:0]                  sel_mid;
	logic [2:0][NUM_W-1:0]       num_mid;
	logic [2:0]                  neg_mid;
	logic [2:0][NUM_W-1:0]       mag_mid;
	logic [2:0][DIV_W-1:0]       dvd_mid;

	assign s_mid   = sq_root[ROOT_W];
	assign sel_mid = sq_pay[ROOT_W][SP_W-1 -: 2];
	assign num_mid = sq_pay[ROOT_W][3*NUM_W-1:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			neg_mid[i] = num_mid[i][NUM_W-1];
			mag_mid[i] = neg_mid[i] ? (NUM_W'(0) - num_mid[i]) : num_mid[i];
			dvd_mid[i] = {1'b0, mag_mid[i][MAG_W-1:0], {FRAC_BITS{1'b0}}}
				+ {{(DIV_W - ROOT_W){1'b0}}, s_mid};
		end
	end

	// Divider chain: one cell per quotient bit, three lanes side by side.
	logic [DIV_W:0]                    dv_valid;
	logic [DIV_W:0]                    dv_ready;
	logic [DIV_W:0][2:0][DIV_W-1:0]    dv_num;
	logic [DIV_W:0][2:0][DEN_W-1:0]    dv_rem;
	logic [DIV_W:0][DEN_W-1:0]         dv_den;
	logic [DIV_W:0][DP_W-1:0]          dv_pay;

	assign dv_valid[0]       = sq_valid[ROOT_W];
	assign sq_ready[ROOT_W]  = dv_ready[0];
	assign dv_num[0]         = {dvd_mid[2], dvd_mid[1], dvd_mid[0]};
	assign dv_rem[0]         = '0;
	assign dv_den[0]         = {s_mid, 1'b0};
	assign dv_pay[0]         = {sel_mid, neg_mid, s_mid};

	for (genvar k = 0; k < DIV_W; k++) begin : g_div
		rm2q_div_cell #(
			.DIV_W (DIV_W),
			.DEN_W (DEN_W),
			.PAY_W (DP_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv_valid[k]),
			.in_ready  (dv_ready[k]),
			.in_num    (dv_num[k]),
			.in_rem    (dv_rem[k]),
			.in_den    (dv_den[k]),
			.in_pay    (dv_pay[k]),
			.out_valid (dv_valid[k+1]),
			.out_ready (dv_ready[k+1]),
			.out_num   (dv_num[k+1]),
			.out_rem   (dv_rem[k+1]),
			.out_den   (dv_den[k+1]),
			.out_pay   (dv_pay[k+1])
		);
	end

	// Back end: saturate each lane, place the lanes and the dominant half component, or give the identity on a zero root.
	function automatic logic [ELEM_W-1:0] sat_lane(input logic neg,
			input logic [DIV_W-1:0] q);
		logic [ELEM_W-1:0] res;
		if (neg) begin
			if (q > DIV_W'(32768)) res = NEG_MAX;
			else                   res = ELEM_W'(0) - q[ELEM_W-1:0];
		end else begin
			if (q > DIV_W'(32767)) res = POS_MAX;
			else                   res = q[ELEM_W-1:0];
		end
		return res;
	endfunction

	logic [ROOT_W-1:0]       s_end;
	logic [2:0]              neg_end;
	sel_t                    sel_end;
	logic [ROOT_W:0]         half_full;
	logic [ELEM_W-1:0]       half_c;
	logic [2:0][ELEM_W-1:0]  lane_c;
	logic [ELEM_W-1:0]       w_c, x_c, y_c, z_c;
	logic                    fb_c;

	assign s_end     = dv_pay[DIV_W][ROOT_W-1:0];
	assign neg_end   = dv_pay[DIV_W][ROOT_W +: 3];
	assign sel_end   = sel_t'(dv_pay[DIV_W][DP_W-1 -: 2]);
	assign half_full = ({1'b0, s_end} + 1'b1) >> 1;
	assign half_c    = (half_full > (ROOT_W+1)'(32767)) ? POS_MAX : half_full[ELEM_W-1:0];
	assign fb_c      = (s_end == '0);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			lane_c[i] = sat_lane(neg_end[i], dv_num[DIV_W][i]);
		end
		if (fb_c) begin
			w_c = ID_W;
			x_c = '0;
			y_c = '0;
			z_c = '0;
		end else begin
			unique case (sel_end)
				SEL_TRACE: begin
					w_c = half_c;    x_c = lane_c[0]; y_c = lane_c[1]; z_c = lane_c[2];
				end
				SEL_X: begin
					w_c = lane_c[0]; x_c = half_c;    y_c = lane_c[1]; z_c = lane_c[2];
				end
				SEL_Y: begin
					w_c = lane_c[0]; x_c = lane_c[1]; y_c = half_c;    z_c = lane_c[2];
				end
				default: begin
					w_c = lane_c[0]; x_c = lane_c[1]; y_c = lane_c[2]; z_c = half_c;
				end
			endcase
		end
	end

	// Output register: it parts the result side from the chains.
	logic              ov_q;
	logic [ELEM_W-1:0] w_q, x_q, y_q, z_q;
	logic              fb_q;

	assign dv_ready[DIV_W] = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (dv_ready[DIV_W]) begin
			ov_q <= dv_valid[DIV_W];
		end
	end

	always_ff @(posedge clk) begin
		if (dv_ready[DIV_W] && dv_valid[DIV_W]) begin
			w_q  <= w_c;
			x_q  <= x_c;
			y_q  <= y_c;
			z_q  <= z_c;
			fb_q <= fb_c;
		end
	end

	assign out_valid         = ov_q;
	assign quat_w            = w_q;
	assign quat_x            = x_q;
	assign quat_y            = y_q;
	assign quat_z            = z_q;
	assign identity_fallback = fb_q;

	// The chosen root argument is never below one, so the root is never zero.
	a_no_fallback: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !identity_fallback)
		else $error("identity fallback taken on a valid result");

	// With the output register empty, every cell can advance and an input transfer is open.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output register is empty");

	// A result moves out only when the divider chain had a finished item in its last cell.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(dv_valid[DIV_W]))
		else $error("result appeared without a finished divider item");

endmodule
